[src/threshold_prune_renormalize_assert.svh]
// ---------------------------------------------------------------------------
// threshold_prune_renormalize assertion macros
// shared concurrent assertion forms, clock and reset fixed by name
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_PRUNE_RENORMALIZE_ASSERT_SVH
`define THRESHOLD_PRUNE_RENORMALIZE_ASSERT_SVH

// same-cycle implication
`define TPR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpr assertion failed");

// next-cycle implication
`define TPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpr assertion failed");

`endif

[src/tpr_pkg.sv]
// ---------------------------------------------------------------------------
// tpr_pkg
// types and constants of the threshold prune and renormalise block
// ---------------------------------------------------------------------------
package tpr_pkg;

   localparam int PROB_BITS      = 17;
   localparam int TARGET_ID_BITS = 20;
   localparam int TOTAL_BITS     = 24;
   localparam int FRAC_BITS      = 16;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   localparam logic CSR_PRUNE_THR      = 1'b0;
   localparam logic CSR_NULL_PRUNE_THR = 1'b1;

   typedef struct packed {
      logic [TARGET_ID_BITS-1:0] target_id;
      logic [PROB_BITS-1:0]      probability;
      logic                      source_is_null;
      logic                      last_entry;
   } req_type;

   typedef struct packed {
      logic [TARGET_ID_BITS-1:0] out_target_id;
      logic [PROB_BITS-1:0]      normalized_prob;
      logic                      entry_valid;
      logic                      last_result;
      logic [TOTAL_BITS-1:0]     total_kept;
   } rsp_type;

   typedef struct packed {
      logic [TARGET_ID_BITS-1:0] target_id;
      logic [PROB_BITS-1:0]      probability;
   } entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUM,
      ST_TOTAL,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

[src/tpr_store.sv]
// ---------------------------------------------------------------------------
// tpr_store
// entry memory, one write and one registered read port
// ---------------------------------------------------------------------------
module tpr_store import tpr_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tpr_div.sv]
// ---------------------------------------------------------------------------
// tpr_div
// restoring divider, one quotient bit a cycle, floor(p * 2^16 / sum)
// ---------------------------------------------------------------------------
module tpr_div import tpr_pkg::*; #(
   parameter int SW = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROB_BITS-1:0] dividend,
   input  logic [SW-1:0]        divisor,
   output logic                 done,
   output logic [PROB_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(PROB_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PROB_BITS - 1);

   logic                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SW:0]          rem_ff, rem_in;
   logic [PROB_BITS-1:0] q_ff, q_in;
   logic                 ge;
   logic [SW:0]          rem_sub;

   // dividend never exceeds divisor, so the first bit is the 2^16 place
   assign ge      = rem_ff >= {1'b0, divisor};
   assign rem_sub = ge ? (rem_ff - {1'b0, divisor}) : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = (SW + 1)'(dividend);
      end else if (busy_ff) begin
         q_in   = {q_ff[PROB_BITS-2:0], ge};
         rem_in = {rem_sub[SW-1:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done     = busy_ff && (cnt_ff == LAST_STEP);
   // zero sum gives zero
   assign quotient = (divisor == '0) ? '0 : {q_ff[PROB_BITS-2:0], ge};

endmodule

[src/threshold_prune_renormalize.sv]
// ---------------------------------------------------------------------------
// threshold_prune_renormalize
// collects a sparse distribution, keeps entries at or above threshold and
// emits them divided by the kept sum
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_data  (one entry a beat)
//  rsp      out        rsp_valid/rsp_stall  rsp_data  (one result a beat)
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  loading: one entry beat per cycle; a non-last beat causes no result
//  last beat: a sum pass streams the stored entries through the store read
//  port, a total step follows, then entry by entry up to the last kept one a
//  read and a check, and for a kept one a serial division in the divider
//  and a result beat
//  req_stall is high outside loading; a stalled rsp beat holds everything
//  reset clears state, fill count, pending flag, kept total and thresholds; the store is not cleared
// ---------------------------------------------------------------------------
`include "threshold_prune_renormalize_assert.svh"

module threshold_prune_renormalize import tpr_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [PROB_BITS-1:0] csr_wdata
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = PROB_BITS + CW;
   localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

   // configuration
   logic [PROB_BITS-1:0] thr_ff, null_thr_ff;

   // control
   state_type            state_ff, state_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        idx_ff, idx_in;      // read pointer of both passes
   logic                 pend_ff, pend_in;    // read data due this cycle
   logic [PROB_BITS-1:0] sel_thr_ff, sel_thr_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        kept_ff, kept_in;
   logic [CW-1:0]        sent_ff, sent_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   rsp_type              rsp_ff, rsp_in;

   // store and divider hookup
   logic                 wr_en, rd_en, div_start, div_done;
   logic [AW-1:0]        rd_addr;
   entry_type            wr_data, rd_data;
   logic [PROB_BITS-1:0] div_q;
   logic                 req_beat, rsp_beat, rd_keep;
   logic [TOTAL_BITS:0]  total_sum;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;
   assign wr_data   = '{target_id: req_data.target_id, probability: req_data.probability};
   assign wr_en     = req_beat && (fill_ff < FULL);
   assign rd_keep   = rd_data.probability >= sel_thr_ff;
   assign total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(kept_ff);

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= '0;
         null_thr_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRUNE_THR:      thr_ff      <= csr_wdata;
            CSR_NULL_PRUNE_THR: null_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tpr_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tpr_div #(.SW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data.probability),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      pend_in    = 1'b0;
      sel_thr_in = sel_thr_ff;
      sum_in     = sum_ff;
      kept_in    = kept_ff;
      sent_in    = sent_ff;
      total_in   = total_ff;
      rsp_in     = rsp_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];
      div_start  = 1'b0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_beat) begin
               if (fill_ff < FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (req_data.last_entry) begin
                  sel_thr_in = req_data.source_is_null ? null_thr_ff : thr_ff;
                  sum_in     = '0;
                  kept_in    = '0;
                  sent_in    = '0;
                  idx_in     = '0;
                  state_in   = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // streamed reads, data handled in the cycle after its address
            if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && rd_keep) begin
               sum_in  = sum_ff + SW'(rd_data.probability);
               kept_in = kept_ff + 1'b1;
            end
            if (!(idx_ff < fill_ff) && !pend_ff) begin
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            total_in = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                       : total_sum[TOTAL_BITS-1:0];
            idx_in   = '0;
            if (kept_ff == '0) begin
               // nothing kept: one invalid closing beat
               rsp_in   = '{out_target_id: '0, normalized_prob: '0, entry_valid: 1'b0,
                            last_result: 1'b1, total_kept: total_in};
               state_in = ST_OUT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            idx_in = idx_ff + 1'b1;
            if (rd_keep) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in  = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               sent_in  = sent_ff + 1'b1;
               rsp_in   = '{out_target_id: rd_data.target_id, normalized_prob: div_q,
                            entry_valid: 1'b1, last_result: (sent_in == kept_ff),
                            total_kept: total_ff};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_beat) begin
               if (rsp_ff.last_result) begin
                  fill_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
      end
      idx_ff     <= idx_in;
      sel_thr_ff <= sel_thr_in;
      sum_ff     <= sum_in;
      kept_ff    <= kept_in;
      sent_ff    <= sent_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // entries are only taken while loading and the fill count never overruns
   `TPR_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FULL)
   // a last beat always starts the sum pass
   `TPR_ASSERT_NEXT(a_last_to_sum, req_beat && req_data.last_entry, state_ff == ST_SUM)
   // kept entries can never outnumber stored ones
   `TPR_ASSERT_IMPL(a_kept_bound, state_ff == ST_TOTAL, kept_ff <= fill_ff)
   // a valid result never shows more beats sent than kept
   `TPR_ASSERT_IMPL(a_sent_bound, rsp_valid && rsp_ff.entry_valid,
                    sent_ff <= kept_ff && sent_ff != '0)

endmodule

[dv/tpr_checker.sv]
// ---------------------------------------------------------------------------
// tpr_checker
// watches the entry, result and register channels of the prune block,
// predicts every result beat and compares it field by field
// ---------------------------------------------------------------------------
module tpr_checker import tpr_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [PROB_BITS-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending_results
);

   logic [PROB_BITS-1:0]  thr_normal, thr_null;
   entry_type             held[$];
   logic [TOTAL_BITS-1:0] running_kept;
   rsp_type               expected_results[$];

   assign pending_results = expected_results.size();

   task automatic report(input string what, input rsp_type exp_r, input rsp_type act_r);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %p actual %p", what, exp_r, act_r);
   endtask

   task automatic close_distribution(input logic is_null);
      logic [PROB_BITS-1:0]  thr;
      logic [40:0]           kept_sum;
      logic [40:0]           quot;
      int                    kept, n;
      logic [TOTAL_BITS:0]   acc;
      rsp_type               r;
      thr = is_null ? thr_null : thr_normal;
      kept_sum = '0;
      kept = 0;
      n = 0;
      foreach (held[i])
         if (held[i].probability >= thr) begin
            kept_sum += held[i].probability;
            kept++;
         end
      acc = {1'b0, running_kept} + (TOTAL_BITS + 1)'(kept);
      running_kept = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_BITS-1:0];
      if (kept == 0) begin
         r = '0;
         r.last_result = 1'b1;
         r.total_kept  = running_kept;
         expected_results.insert(expected_results.size(), r);
      end else begin
         foreach (held[i])
            if (held[i].probability >= thr) begin
               quot = (kept_sum != 0) ? ({24'd0, held[i].probability} << FRAC_BITS) / kept_sum
                                      : '0;
               n++;
               r.out_target_id   = held[i].target_id;
               r.normalized_prob = quot[PROB_BITS-1:0];
               r.entry_valid     = 1'b1;
               r.last_result     = (n == kept);
               r.total_kept      = running_kept;
               expected_results.insert(expected_results.size(), r);
            end
      end
      held.delete();
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         thr_normal   = '0;
         thr_null     = '0;
         running_kept = '0;
         held.delete();
         expected_results.delete();
         fail_count   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PRUNE_THR) thr_normal = csr_wdata;
            else                            thr_null   = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0)
               report("unexpected beat", '0, rsp_data);
            else begin
               exp_r = expected_results.pop_front();
               if (exp_r.out_target_id !== rsp_data.out_target_id ||
                   exp_r.normalized_prob !== rsp_data.normalized_prob ||
                   exp_r.entry_valid !== rsp_data.entry_valid ||
                   exp_r.last_result !== rsp_data.last_result ||
                   exp_r.total_kept !== rsp_data.total_kept)
                  report("result field", exp_r, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            if (held.size() < MAX_ENTRIES)
               held.insert(held.size(), entry_type'{target_id: req_data.target_id,
                                                    probability: req_data.probability});
            if (req_data.last_entry)
               close_distribution(req_data.source_is_null);
         end
      end
   end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// drives distributions and threshold writes into the prune block; a checker
// beside it predicts and compares every result beat
// ---------------------------------------------------------------------------
module testbench;
   import tpr_pkg::*;

   localparam int MAX_ENTRIES = 64;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_index;
   logic [PROB_BITS-1:0] csr_wdata;
   int                   fail_count;
   int                   pending_results;
   int                   sent_entries;
   bit                   calm;   // no idling in this stretch

   threshold_prune_renormalize #(.MAX_ENTRIES(MAX_ENTRIES)) dut (.*);

   tpr_checker #(.MAX_ENTRIES(MAX_ENTRIES)) checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side stall, random except in calm stretches
   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : (!calm && $urandom_range(99) < 20);

   // one entry beat, with an optional idle gap in front
   task automatic send_entry(input logic [TARGET_ID_BITS-1:0] id,
                             input logic [PROB_BITS-1:0] prob,
                             input logic is_null, input logic last);
      while (!calm && $urandom_range(99) < 20) @(negedge clock);
      req_valid = 1'b1;
      req_data  = '{target_id: id, probability: prob,
                    source_is_null: is_null, last_entry: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      sent_entries++;
   endtask

   // wait for all results, then let the block settle before a register write
   task automatic drain();
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_thresholds(input logic [PROB_BITS-1:0] thr_n,
                                   input logic [PROB_BITS-1:0] thr_z);
      for (int i = 0; i < 2; i++) begin
         csr_valid = 1'b1;
         csr_index = (i == 0) ? CSR_PRUNE_THR : CSR_NULL_PRUNE_THR;
         csr_wdata = (i == 0) ? thr_n : thr_z;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
         csr_valid = 1'b0;
      end
   endtask

   // random probability, weighted to the edges of the range
   function automatic logic [PROB_BITS-1:0] pick_prob();
      case ($urandom_range(9))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'($urandom_range(65535, 60000));
         3:       return 17'($urandom_range(7));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic send_distribution(input int len, input logic is_null);
      for (int i = 0; i < len; i++)
         send_entry(20'($urandom), pick_prob(), 1'($urandom_range(1)), i == len - 1);
      // null flag only counts on the last beat; is_null is used only when len is zero
      if (len == 0) send_entry(20'($urandom), pick_prob(), is_null, 1'b1);
   endtask

   initial begin
      int len;
      int round;
      req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = CSR_PRUNE_THR; csr_wdata = '0;
      sent_entries = 0; calm = 1'b0; round = 0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes with zero thresholds
      send_entry(20'hFFFFF, 17'd65536, 1'b0, 1'b0);
      send_entry(20'h00000, 17'd0, 1'b1, 1'b0);
      send_entry(20'hAAAAA, 17'd1, 1'b0, 1'b1);
      // zero kept sum
      send_entry(20'h55555, 17'd0, 1'b0, 1'b0);
      send_entry(20'h12345, 17'd0, 1'b0, 1'b1);
      // single entry
      send_entry(20'h0F0F0, 17'd32768, 1'b1, 1'b1);
      drain();
      write_thresholds(17'd65536, 17'd1);
      // nothing kept on normal, null flag taken from last beat only
      send_entry(20'h00001, 17'd65535, 1'b1, 1'b0);
      send_entry(20'h00002, 17'd100, 1'b0, 1'b1);
      send_entry(20'h00003, 17'd0, 1'b0, 1'b0);
      send_entry(20'h00004, 17'd5, 1'b1, 1'b1);
      send_entry(20'h00005, 17'd65536, 1'b0, 1'b1);
      drain();
      // store overflow: extra entries dropped
      write_thresholds(17'd0, 17'd65536);
      for (int i = 0; i < MAX_ENTRIES + 3; i++)
         send_entry(20'(i), 17'($urandom_range(65536)), 1'b0, i == MAX_ENTRIES + 2);
      drain();

      // random distributions under a range of thresholds
      while (sent_entries < 320) begin
         case ($urandom_range(4))
            0: write_thresholds(17'd0, 17'd65536);
            1: write_thresholds(17'd65536, 17'd0);
            default: write_thresholds(17'($urandom_range(65536)),
                                      17'($urandom_range(65536)));
         endcase
         round++;
         // the first round always runs without idling
         calm = (round == 1) || ($urandom_range(5) == 0);
         for (int d = 0; d < 4; d++) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(MAX_ENTRIES + 2, 20)
                                            : $urandom_range(8, 1);
            send_distribution(len, 1'b0);
         end
         calm = 1'b0;
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/tpr_pkg.sv
src/tpr_store.sv
src/tpr_div.sv
src/threshold_prune_renormalize.sv
dv/tpr_checker.sv
dv/testbench.sv
